// ===== rtl/pes_pkg.sv =====
package pes_pkg;

  localparam int MAX_VERTS_DEF   = 16;
  localparam int COORD_WIDTH_DEF = 24;

  localparam int EDGE_NUM_W = 6;
  localparam int COEF_W     = 16;
  localparam int CONST_W    = 28;
  localparam int FRAC_BITS  = 14;
  // quotient of 2^30 * u^2 / (u^2 + w^2), and its square root
  localparam int QUO_W      = 31;
  localparam int DIV_STEPS  = 30;
  localparam int ROOT_STEPS = 16;
  localparam int STEP_W     = 5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_OFFS,
    ST_DOT,
    ST_SIGN,
    ST_SQ,
    ST_DIVINIT,
    ST_DIV,
    ST_RINIT,
    ST_ROOT,
    ST_UNIT,
    ST_CMUL,
    ST_CFIN,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_READ,
    DP_DIFF,
    DP_OFFS,
    DP_DOT,
    DP_SIGN,
    DP_SQ,
    DP_DIVINIT,
    DP_DIV,
    DP_RINIT,
    DP_ROOT,
    DP_UNIT,
    DP_CMUL,
    DP_CFIN,
    DP_CLEAR
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic last_edge;
  } dp_status_t;

endpackage

// ===== rtl/pes_vertex_if.sv =====
interface pes_vertex_if #(
  parameter int COORD_WIDTH = pes_pkg::COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vertex_x;
  logic signed [COORD_WIDTH-1:0] vertex_y;
  logic                          final_vertex;

  modport source (output valid, vertex_x, vertex_y, final_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, final_vertex, output ready);
endinterface

// ===== rtl/pes_equation_if.sv =====
interface pes_equation_if #(
  parameter int COORD_WIDTH = pes_pkg::COORD_WIDTH_DEF
);
  logic                                  valid;
  logic                                  ready;
  logic [pes_pkg::EDGE_NUM_W-1:0]        edge_number;
  logic signed [pes_pkg::COEF_W-1:0]     coef_a;
  logic signed [pes_pkg::COEF_W-1:0]     coef_b;
  logic signed [pes_pkg::CONST_W-1:0]    coef_c;
  logic signed [COORD_WIDTH-1:0]         box_min_x;
  logic signed [COORD_WIDTH-1:0]         box_min_y;
  logic signed [COORD_WIDTH-1:0]         box_max_x;
  logic signed [COORD_WIDTH-1:0]         box_max_y;
  logic                                  degenerate_edge;
  logic                                  vertices_dropped;
  logic                                  last_edge;

  modport source (
    output valid, edge_number, coef_a, coef_b, coef_c, box_min_x, box_min_y,
           box_max_x, box_max_y, degenerate_edge, vertices_dropped, last_edge,
    input  ready
  );
  modport sink (
    input  valid, edge_number, coef_a, coef_b, coef_c, box_min_x, box_min_y,
           box_max_x, box_max_y, degenerate_edge, vertices_dropped, last_edge,
    output ready
  );
endinterface

// ===== rtl/pes_datapath.sv =====
module pes_datapath #(
  parameter int MAX_VERTS   = pes_pkg::MAX_VERTS_DEF,
  parameter int COORD_WIDTH = pes_pkg::COORD_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pes_pkg::dp_cmd_t                     cmd,
  input  logic [$clog2(MAX_VERTS+1)-1:0]       edge_idx,
  output pes_pkg::dp_status_t                  status,
  input  logic signed [COORD_WIDTH-1:0]        vertex_x,
  input  logic signed [COORD_WIDTH-1:0]        vertex_y,
  output logic [pes_pkg::EDGE_NUM_W-1:0]       edge_number,
  output logic signed [pes_pkg::COEF_W-1:0]    coef_a,
  output logic signed [pes_pkg::COEF_W-1:0]    coef_b,
  output logic signed [pes_pkg::CONST_W-1:0]   coef_c,
  output logic signed [COORD_WIDTH-1:0]        box_min_x,
  output logic signed [COORD_WIDTH-1:0]        box_min_y,
  output logic signed [COORD_WIDTH-1:0]        box_max_x,
  output logic signed [COORD_WIDTH-1:0]        box_max_y,
  output logic                                 degenerate_edge,
  output logic                                 vertices_dropped,
  output logic                                 last_edge
);
  localparam int CW   = COORD_WIDTH;
  localparam int CNTW = $clog2(MAX_VERTS+1);
  localparam int AW   = $clog2(MAX_VERTS);
  localparam int SUMW = CW + CNTW;
  localparam int NPW  = CW + CNTW + 1;
  localparam int DXW  = CW + CNTW + 2;
  localparam int NW   = CW + 1;
  localparam int PW   = DXW + NW;
  localparam int SQW  = 2 * CW;
  localparam int RMW  = SQW + 1;
  localparam int QW   = pes_pkg::QUO_W;
  localparam int KW   = pes_pkg::COEF_W - 1;
  localparam int CPW  = pes_pkg::COEF_W + CW;
  localparam int SW   = CPW + 1;
  localparam int RW   = (SW - pes_pkg::FRAC_BITS + 1 > pes_pkg::CONST_W + 1) ?
                        SW - pes_pkg::FRAC_BITS + 1 : pes_pkg::CONST_W + 1;
  localparam logic [RW-1:0] C_NEG_LIM = RW'(1) << (pes_pkg::CONST_W - 1);
  localparam logic [RW-1:0] C_POS_LIM = C_NEG_LIM - RW'(1);
  localparam logic signed [CW-1:0] TOP = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] BOT = {1'b1, {(CW-1){1'b0}}};

  logic [2*CW-1:0] mem [MAX_VERTS];
  logic [2*CW-1:0] rd_a, rd_b;

  logic [CNTW-1:0]        count;
  logic signed [SUMW-1:0] sum_x, sum_y;
  logic signed [CW-1:0]   bmin_x, bmin_y, bmax_x, bmax_y;
  logic                   ovf;

  logic signed [CW-1:0]  px, py;
  logic signed [NW-1:0]  nx, ny;
  logic                  degen;
  logic signed [DXW-1:0] dx, dy;
  logic signed [PW-1:0]  pdx, pdy;
  logic [CW-1:0]         um, wm;
  logic                  sgnx, sgny;
  logic [SQW-1:0]        su, sw;
  logic [RMW-1:0]        ssum;
  logic [RMW-1:0]        rem_a, rem_b;
  logic [QW-1:0]         quo_a, quo_b;
  logic [QW-1:0]         num_a, num_b, res_a, res_b, rbit;
  logic signed [pes_pkg::COEF_W-1:0] ca, cb;
  logic signed [CPW-1:0] pa, pb;

  logic [CNTW-1:0]       nxt_idx;
  logic                  is_last;
  logic signed [NPW-1:0] npx, npy;
  logic signed [PW:0]    dsum;
  logic signed [NW-1:0]  fx, fy;
  logic [RMW:0]          sh_a, sh_b;
  logic                  ge_a, ge_b;
  logic [QW-1:0]         t_a, t_b;
  logic [KW+1:0]         k_a, k_b;
  logic signed [SW-1:0]  s_sum;
  logic [SW-1:0]         s_mag;
  logic [RW-1:0]         r_abs;
  logic signed [pes_pkg::CONST_W-1:0] c_val;

  always_comb begin
    is_last = (edge_idx + CNTW'(1)) == count;
    nxt_idx = is_last ? '0 : edge_idx + CNTW'(1);
    status.last_edge = is_last;

    npx = $signed({1'b0, count}) * px;
    npy = $signed({1'b0, count}) * py;

    // centroid test, flip normal when it points away
    dsum = (PW+1)'(pdx) + (PW+1)'(pdy);
    fx = dsum[PW] ? -nx : nx;
    fy = dsum[PW] ? -ny : ny;

    sh_a = {rem_a, 1'b0};
    sh_b = {rem_b, 1'b0};
    ge_a = sh_a >= {1'b0, ssum};
    ge_b = sh_b >= {1'b0, ssum};

    t_a = res_a + rbit;
    t_b = res_b + rbit;
    k_a = ((KW+2)'(res_a) + (KW+2)'(1)) >> 1;
    k_b = ((KW+2)'(res_b) + (KW+2)'(1)) >> 1;

    s_sum = SW'(pa) + SW'(pb);
    s_mag = s_sum[SW-1] ? SW'(-s_sum) : SW'(s_sum);
    r_abs = RW'((s_mag + SW'(1 << (pes_pkg::FRAC_BITS - 1))) >> pes_pkg::FRAC_BITS);
    if (s_sum[SW-1]) begin
      c_val = (r_abs > C_POS_LIM) ? pes_pkg::CONST_W'(C_POS_LIM)
                                  : pes_pkg::CONST_W'(r_abs);
    end else begin
      c_val = (r_abs > C_NEG_LIM) ? -pes_pkg::CONST_W'(C_NEG_LIM)
                                  : -pes_pkg::CONST_W'(r_abs);
    end
  end

  // vertex store, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.op == pes_pkg::DP_LOAD && count < CNTW'(MAX_VERTS)) begin
      mem[count[AW-1:0]] <= {vertex_x, vertex_y};
    end
    if (cmd.op == pes_pkg::DP_READ) begin
      rd_a <= mem[edge_idx[AW-1:0]];
      rd_b <= mem[nxt_idx[AW-1:0]];
    end
  end

  // polygon accumulators
  always_ff @(posedge clk) begin
    if (rst || cmd.op == pes_pkg::DP_CLEAR) begin
      count  <= '0;
      sum_x  <= '0;
      sum_y  <= '0;
      bmin_x <= TOP;
      bmin_y <= TOP;
      bmax_x <= BOT;
      bmax_y <= BOT;
      ovf    <= 1'b0;
    end else if (cmd.op == pes_pkg::DP_LOAD) begin
      if (count < CNTW'(MAX_VERTS)) begin
        count <= count + CNTW'(1);
        sum_x <= sum_x + SUMW'(vertex_x);
        sum_y <= sum_y + SUMW'(vertex_y);
        if (vertex_x < bmin_x) bmin_x <= vertex_x;
        if (vertex_y < bmin_y) bmin_y <= vertex_y;
        if (vertex_x > bmax_x) bmax_x <= vertex_x;
        if (vertex_y > bmax_y) bmax_y <= vertex_y;
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  // per-edge arithmetic
  always_ff @(posedge clk) begin
    case (cmd.op)
      pes_pkg::DP_DIFF: begin
        px    <= rd_a[2*CW-1:CW];
        py    <= rd_a[CW-1:0];
        nx    <= NW'($signed(rd_a[CW-1:0])) - NW'($signed(rd_b[CW-1:0]));
        ny    <= NW'($signed(rd_b[2*CW-1:CW])) - NW'($signed(rd_a[2*CW-1:CW]));
        degen <= (rd_a == rd_b);
      end
      pes_pkg::DP_OFFS: begin
        dx <= DXW'(sum_x) - DXW'(npx);
        dy <= DXW'(sum_y) - DXW'(npy);
      end
      pes_pkg::DP_DOT: begin
        pdx <= dx * nx;
        pdy <= dy * ny;
      end
      pes_pkg::DP_SIGN: begin
        sgnx <= fx[NW-1];
        sgny <= fy[NW-1];
        um   <= fx[NW-1] ? CW'(-fx) : CW'(fx);
        wm   <= fy[NW-1] ? CW'(-fy) : CW'(fy);
      end
      pes_pkg::DP_SQ: begin
        su <= um * um;
        sw <= wm * wm;
      end
      pes_pkg::DP_DIVINIT: begin
        // top quotient bit is set only when the other part is zero
        ssum  <= RMW'(su) + RMW'(sw);
        rem_a <= (sw == '0) ? '0 : RMW'(su);
        rem_b <= (su == '0) ? '0 : RMW'(sw);
        quo_a <= QW'(sw == '0);
        quo_b <= QW'(su == '0);
      end
      pes_pkg::DP_DIV: begin
        rem_a <= ge_a ? RMW'(sh_a - {1'b0, ssum}) : RMW'(sh_a);
        rem_b <= ge_b ? RMW'(sh_b - {1'b0, ssum}) : RMW'(sh_b);
        quo_a <= {quo_a[QW-2:0], ge_a};
        quo_b <= {quo_b[QW-2:0], ge_b};
      end
      pes_pkg::DP_RINIT: begin
        num_a <= quo_a;
        num_b <= quo_b;
        res_a <= '0;
        res_b <= '0;
        rbit  <= QW'(1) << (QW - 1);
      end
      pes_pkg::DP_ROOT: begin
        if (num_a >= t_a) begin
          num_a <= num_a - t_a;
          res_a <= (res_a >> 1) + rbit;
        end else begin
          res_a <= res_a >> 1;
        end
        if (num_b >= t_b) begin
          num_b <= num_b - t_b;
          res_b <= (res_b >> 1) + rbit;
        end else begin
          res_b <= res_b >> 1;
        end
        rbit <= rbit >> 2;
      end
      pes_pkg::DP_UNIT: begin
        ca <= sgnx ? -pes_pkg::COEF_W'(k_a) : pes_pkg::COEF_W'(k_a);
        cb <= sgny ? -pes_pkg::COEF_W'(k_b) : pes_pkg::COEF_W'(k_b);
      end
      pes_pkg::DP_CMUL: begin
        pa <= ca * px;
        pb <= cb * py;
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.op == pes_pkg::DP_CFIN) begin
      edge_number      <= pes_pkg::EDGE_NUM_W'(edge_idx);
      coef_a           <= degen ? '0 : ca;
      coef_b           <= degen ? '0 : cb;
      coef_c           <= degen ? '0 : c_val;
      box_min_x        <= bmin_x;
      box_min_y        <= bmin_y;
      box_max_x        <= bmax_x;
      box_max_y        <= bmax_y;
      degenerate_edge  <= degen;
      vertices_dropped <= ovf;
      last_edge        <= is_last;
    end
  end

endmodule

// ===== rtl/pes_controller.sv =====
module pes_controller #(
  parameter int MAX_VERTS = pes_pkg::MAX_VERTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_final,
  output logic                           in_ready,
  output logic                           out_valid,
  input  logic                           out_ready,
  output pes_pkg::dp_cmd_t               cmd,
  output logic [$clog2(MAX_VERTS+1)-1:0] edge_idx,
  input  pes_pkg::dp_status_t            status
);
  localparam int CNTW = $clog2(MAX_VERTS+1);

  pes_pkg::state_t state, state_next;
  logic [CNTW-1:0] edge_idx_next;
  logic [pes_pkg::STEP_W-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pes_pkg::ST_IDLE;
      edge_idx <= '0;
      step     <= '0;
    end else begin
      state    <= state_next;
      edge_idx <= edge_idx_next;
      step     <= step_next;
    end
  end

  always_comb begin
    state_next    = state;
    edge_idx_next = edge_idx;
    step_next     = step;
    cmd.op        = pes_pkg::DP_NOP;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    unique case (state)
      pes_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = pes_pkg::DP_LOAD;
          if (in_final) begin
            edge_idx_next = '0;
            state_next    = pes_pkg::ST_READ;
          end
        end
      end
      pes_pkg::ST_READ: begin
        cmd.op     = pes_pkg::DP_READ;
        state_next = pes_pkg::ST_DIFF;
      end
      pes_pkg::ST_DIFF: begin
        cmd.op     = pes_pkg::DP_DIFF;
        state_next = pes_pkg::ST_OFFS;
      end
      pes_pkg::ST_OFFS: begin
        cmd.op     = pes_pkg::DP_OFFS;
        state_next = pes_pkg::ST_DOT;
      end
      pes_pkg::ST_DOT: begin
        cmd.op     = pes_pkg::DP_DOT;
        state_next = pes_pkg::ST_SIGN;
      end
      pes_pkg::ST_SIGN: begin
        cmd.op     = pes_pkg::DP_SIGN;
        state_next = pes_pkg::ST_SQ;
      end
      pes_pkg::ST_SQ: begin
        cmd.op     = pes_pkg::DP_SQ;
        state_next = pes_pkg::ST_DIVINIT;
      end
      pes_pkg::ST_DIVINIT: begin
        cmd.op     = pes_pkg::DP_DIVINIT;
        step_next  = '0;
        state_next = pes_pkg::ST_DIV;
      end
      pes_pkg::ST_DIV: begin
        cmd.op    = pes_pkg::DP_DIV;
        step_next = step + pes_pkg::STEP_W'(1);
        if (step == pes_pkg::STEP_W'(pes_pkg::DIV_STEPS - 1)) begin
          state_next = pes_pkg::ST_RINIT;
        end
      end
      pes_pkg::ST_RINIT: begin
        cmd.op     = pes_pkg::DP_RINIT;
        step_next  = '0;
        state_next = pes_pkg::ST_ROOT;
      end
      pes_pkg::ST_ROOT: begin
        cmd.op    = pes_pkg::DP_ROOT;
        step_next = step + pes_pkg::STEP_W'(1);
        if (step == pes_pkg::STEP_W'(pes_pkg::ROOT_STEPS - 1)) begin
          state_next = pes_pkg::ST_UNIT;
        end
      end
      pes_pkg::ST_UNIT: begin
        cmd.op     = pes_pkg::DP_UNIT;
        state_next = pes_pkg::ST_CMUL;
      end
      pes_pkg::ST_CMUL: begin
        cmd.op     = pes_pkg::DP_CMUL;
        state_next = pes_pkg::ST_CFIN;
      end
      pes_pkg::ST_CFIN: begin
        cmd.op     = pes_pkg::DP_CFIN;
        state_next = pes_pkg::ST_OUT;
      end
      pes_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.last_edge) begin
            cmd.op     = pes_pkg::DP_CLEAR;
            state_next = pes_pkg::ST_IDLE;
          end else begin
            edge_idx_next = edge_idx + CNTW'(1);
            state_next    = pes_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_next = pes_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/polygon_edge_equation_setup.sv =====
// Convex polygon edge-equation setup. Vertices arrive one beat per cycle as
// signed Q15.8 points, the last one marked final_vertex; up to MAX_VERTS are
// kept, further ones are dropped and reported. After the final vertex one
// equation a*x+b*y+c>=0 is delivered per closing edge, with a and b the unit
// inward normal in Q1.14 and c in Q.8, plus the polygon's bounding box.
// Each edge then passes through the setup steps (store read, edge vector,
// centroid offset, dot product, normal flip, squares, divider load), the
// bit-per-cycle divider that forms 2^30*u^2/(u^2+w^2) for both parts, a
// load and the digit-by-digit square root, the coefficients and constant
// term, and the presentation of the result, which is held while the output
// stalls. No vertex is taken while edges are being emitted.
module polygon_edge_equation_setup #(
  parameter int MAX_VERTS   = pes_pkg::MAX_VERTS_DEF,
  parameter int COORD_WIDTH = pes_pkg::COORD_WIDTH_DEF
) (
  input logic clk,
  input logic rst,
  pes_vertex_if.sink     vertex,
  pes_equation_if.source equation
);
  localparam int CNTW = $clog2(MAX_VERTS+1);

  // command and status between sequencer and datapath
  pes_pkg::dp_cmd_t    cmd;
  pes_pkg::dp_status_t status;
  logic [CNTW-1:0]     edge_idx;

  pes_controller #(
    .MAX_VERTS (MAX_VERTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vertex.valid),
    .in_final  (vertex.final_vertex),
    .in_ready  (vertex.ready),
    .out_valid (equation.valid),
    .out_ready (equation.ready),
    .cmd       (cmd),
    .edge_idx  (edge_idx),
    .status    (status)
  );

  // vertex store, accumulators, divider and root units, result register
  pes_datapath #(
    .MAX_VERTS   (MAX_VERTS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .edge_idx         (edge_idx),
    .status           (status),
    .vertex_x         (vertex.vertex_x),
    .vertex_y         (vertex.vertex_y),
    .edge_number      (equation.edge_number),
    .coef_a           (equation.coef_a),
    .coef_b           (equation.coef_b),
    .coef_c           (equation.coef_c),
    .box_min_x        (equation.box_min_x),
    .box_min_y        (equation.box_min_y),
    .box_max_x        (equation.box_max_x),
    .box_max_y        (equation.box_max_y),
    .degenerate_edge  (equation.degenerate_edge),
    .vertices_dropped (equation.vertices_dropped),
    .last_edge        (equation.last_edge)
  );

`ifndef ASSERT_OFF
  // a vertex is never taken while an equation is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(vertex.valid && vertex.ready && equation.valid))
    else $error("vertex accepted during edge emission");

  // a zero-length edge carries zero coefficients
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (equation.valid && equation.degenerate_edge) |->
      (equation.coef_a == '0 && equation.coef_b == '0 && equation.coef_c == '0))
    else $error("degenerate edge with non-zero coefficients");

  // a proper edge has a non-zero unit normal
  a_normal_nonzero: assert property (@(posedge clk) disable iff (rst)
    (equation.valid && !equation.degenerate_edge) |->
      (equation.coef_a != '0 || equation.coef_b != '0))
    else $error("proper edge with zero normal");
`endif

endmodule
